@@ hw/rtl/spimb_pkg.sv @@
// Package for the buffered SPI master controller.
// Holds the mode, layout and register codes plus the clock and mode decoders.
// No dependencies.
package spimb_pkg;

   localparam int BUFFER_BYTES_DEF   = 64;
   localparam int REGISTER_WORDS_DEF = 64;
   localparam int BUF_WORD_W         = 4;   // word index width at the largest buffer

   localparam logic [1:0] MODE_WR  = 2'd0;
   localparam logic [1:0] MODE_RD  = 2'd1;
   localparam logic [1:0] MODE_XCH = 2'd2;

   localparam logic [1:0] LAY_NEW = 2'd0;
   localparam logic [1:0] LAY_LEG = 2'd2;

   localparam logic CSR_LAYOUT   = 1'b0;
   localparam logic CSR_SEL_USED = 1'b1;

   localparam logic [1:0] ROLE_MASTER = 2'd1;
   localparam logic [1:0] ROLE_SLAVE  = 2'd2;

   // Words kept in flops because the control logic reads them at fixed places
   localparam int SP_N = 14;
   localparam logic [3:0] SP_00 = 4'd0;
   localparam logic [3:0] SP_08 = 4'd1;
   localparam logic [3:0] SP_0C = 4'd2;
   localparam logic [3:0] SP_10 = 4'd3;
   localparam logic [3:0] SP_18 = 4'd4;
   localparam logic [3:0] SP_1C = 4'd5;
   localparam logic [3:0] SP_20 = 4'd6;
   localparam logic [3:0] SP_28 = 4'd7;
   localparam logic [3:0] SP_2C = 4'd8;
   localparam logic [3:0] SP_30 = 4'd9;
   localparam logic [3:0] SP_34 = 4'd10;
   localparam logic [3:0] SP_38 = 4'd11;
   localparam logic [3:0] SP_3C = 4'd12;
   localparam logic [3:0] SP_E0 = 4'd13;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } sp_sel_type;

   typedef struct packed {
      logic pol;
      logic pha;
      logic ord;
   } spi_mode_type;

   typedef struct packed {
      logic                  we;
      logic [BUF_WORD_W-1:0] wr_word;
      logic [3:0]            be;
      logic [31:0]           wdata;
      logic                  rd_a_en;
      logic [BUF_WORD_W-1:0] rd_a_word;
      logic                  rd_b_en;
      logic [BUF_WORD_W-1:0] rd_b_word;
   } dbuf_ctl_type;

   function automatic sp_sel_type sp_lookup(input logic [7:0] off);
      sp_sel_type s;
      s.hit = 1'b1;
      s.idx = SP_00;
      case (off)
         8'h00: s.idx = SP_00;
         8'h08: s.idx = SP_08;
         8'h0C: s.idx = SP_0C;
         8'h10: s.idx = SP_10;
         8'h18: s.idx = SP_18;
         8'h1C: s.idx = SP_1C;
         8'h20: s.idx = SP_20;
         8'h28: s.idx = SP_28;
         8'h2C: s.idx = SP_2C;
         8'h30: s.idx = SP_30;
         8'h34: s.idx = SP_34;
         8'h38: s.idx = SP_38;
         8'h3C: s.idx = SP_3C;
         8'hE0: s.idx = SP_E0;
         default: s.hit = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic [19:0] decode_clock(input logic [31:0] v, input logic is_new);
      logic [13:0] pre;
      logic [6:0]  n;
      logic [20:0] prod;
      pre  = is_new ? {10'd0, v[21:18]} : {1'b0, v[30:18]};
      pre  = pre + 14'd1;
      n    = {1'b0, v[17:12]} + 7'd1;
      prod = pre * n;
      return v[31] ? 20'd1 : prod[19:0];
   endfunction

   function automatic spi_mode_type decode_mode(input logic [31:0] user, input logic [31:0] misc,
                                                input logic [31:0] ctrl, input logic is_new);
      spi_mode_type m;
      logic outedge;
      outedge = is_new ? user[9] : user[7];
      m.pol   = misc[29];
      m.pha   = outedge ^ misc[29];
      m.ord   = is_new ? (|ctrl[26:25]) : ctrl[26];
      return m;
   endfunction

endpackage

@@ hw/rtl/spimb_dbuf.sv @@
// Data buffer of the SPI master: byte-enabled write port, two registered read ports.
// Unwritten bytes read as zero through per-byte valid flops. Uses spimb_pkg.
module spimb_dbuf
   import spimb_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  dbuf_ctl_type ctl,
   output logic [31:0]  rd_a_data,
   output logic [31:0]  rd_b_data
);

   localparam int WORDS = (BUFFER_BYTES + 3) / 4;
   localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [31:0]          mem [WORDS];
   logic [WORDS-1:0][3:0] vld_ff;
   logic [31:0]          rd_a_ff;
   logic [31:0]          rd_b_ff;
   logic [WIDX-1:0]      wr_w;
   logic [WIDX-1:0]      ra_w;
   logic [WIDX-1:0]      rb_w;

   assign wr_w = ctl.wr_word[WIDX-1:0];
   assign ra_w = ctl.rd_a_word[WIDX-1:0];
   assign rb_w = ctl.rd_b_word[WIDX-1:0];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         for (int l = 0; l < 4; l++) begin
            if (ctl.be[l]) begin
               mem[wr_w][8*l +: 8] <= ctl.wdata[8*l +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.we) begin
         vld_ff[wr_w] <= vld_ff[wr_w] | ctl.be;
      end
   end

   // read before write: a beat writes one lane and reads another
   always_ff @(posedge clock) begin
      if (ctl.rd_a_en) begin
         for (int l = 0; l < 4; l++) begin
            rd_a_ff[8*l +: 8] <= vld_ff[ra_w][l] ? mem[ra_w][8*l +: 8] : 8'd0;
         end
      end
      if (ctl.rd_b_en) begin
         for (int l = 0; l < 4; l++) begin
            rd_b_ff[8*l +: 8] <= vld_ff[rb_w][l] ? mem[rb_w][8*l +: 8] : 8'd0;
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ hw/rtl/spi_master_buffered_controller_top.sv @@
// Top level of the buffered SPI master controller: register store, decoders, transfer control.
// Depends on spimb_pkg and spimb_dbuf.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------------------
//   request  | in        | start & !busy        | req_mode, req_byte_offset, req_write_value,
//            |           |                      | req_received_byte
//   response | out       | rsp_valid, 1 cycle   | rsp_read_value .. rsp_role
//   csr      | in        | csr_we               | csr_index, csr_wdata
//
// One beat is accepted every cycle; busy stays low. The response of a beat appears in the
// cycle after it is accepted, set by the registered read ports of the register store and
// the data buffer. Synchronous reset clears the control state and the valid flops of both
// stores. The receiver cannot stall; a response lasts one cycle.
module spi_master_buffered_controller_top
   import spimb_pkg::*;
#(
   parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
   parameter int REGISTER_WORDS = REGISTER_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_byte_offset,
   input  logic [31:0] req_write_value,
   input  logic [7:0]  req_received_byte,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_value,
   output logic        rsp_send_start,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_select_low,
   output logic        rsp_busy_res,
   output logic [19:0] rsp_clock_divider,
   output logic        rsp_idle_high,
   output logic        rsp_sample_trailing,
   output logic        rsp_lsb_first,
   output logic [1:0]  rsp_role,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);

   localparam int RIDX = $clog2(REGISTER_WORDS);
   localparam logic [8:0] BUF_LEN = 9'(BUFFER_BYTES);
   localparam logic [6:0] BUF_MAX = 7'(BUFFER_BYTES);

   localparam logic [1:0] RSEL_NONE = 2'd0;
   localparam logic [1:0] RSEL_MEM  = 2'd1;
   localparam logic [1:0] RSEL_SPEC = 2'd2;
   localparam logic [1:0] RSEL_BUF  = 2'd3;

   logic [1:0]  lay_ff;
   logic        sel_used_ff;
   logic [31:0] sp_ff [SP_N];
   logic [31:0] sp_in [SP_N];
   logic        active_ff, active_in;
   logic [6:0]  byte_idx_ff, byte_idx_in;
   logic [6:0]  byte_cnt_ff, byte_cnt_in;
   logic [19:0] div_ff, div_in;
   logic        pol_ff, pol_in;
   logic        pha_ff, pha_in;
   logic        ord_ff, ord_in;
   logic [1:0]  role_ff, role_in;
   logic        select_ff, select_in;

   logic        rsp_vld_ff;
   logic        send_ff, send_in;
   logic [1:0]  lane_ff, lane_in;
   logic [1:0]  rsel_ff, rsel_in;
   logic [31:0] spec_rd_ff;
   logic [31:0] mem_rd_ff;

   logic [31:0]             reg_mem [REGISTER_WORDS];
   logic [REGISTER_WORDS-1:0] reg_vld_ff;
   logic                    mem_we;
   logic                    mem_re;
   logic [RIDX-1:0]         widx;

   dbuf_ctl_type dctl;
   logic [31:0]  buf_rd_a;
   logic [31:0]  buf_rd_b;

   logic         acc;
   logic         is_new;
   logic         is_leg;
   logic [7:0]   off;
   sp_sel_type   sps;
   logic [8:0]   base;
   logic [8:0]   win_diff;
   logic         in_win;
   logic [7:0]   clk_off, user_off, misc_off, slave_off;
   logic [3:0]   done_idx, slave_idx;
   logic [31:0]  done_mask, cmd_mask;
   logic [31:0]  user_v, misc_v, clk_v;
   logic [31:0]  w0;
   logic [24:0]  bits, bits_a, bits_b;
   logic [24:0]  bytes_rnd;
   logic [21:0]  nbytes;
   logic [6:0]   cnt;
   logic [6:0]   nidx;
   spi_mode_type md;

   assign busy = 1'b0;
   assign acc  = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         lay_ff      <= 2'd1;
         sel_used_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYOUT:   lay_ff      <= csr_wdata;
            CSR_SEL_USED: sel_used_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // layout three behaves as the classic layout
   assign is_new    = (lay_ff == LAY_NEW);
   assign is_leg    = (lay_ff == LAY_LEG);
   assign off       = {req_byte_offset[7:2], 2'b00};
   assign widx      = RIDX'(req_byte_offset[7:2]);
   assign sps       = sp_lookup(off);
   assign base      = is_new ? 9'h098 : (is_leg ? 9'h040 : 9'h080);
   assign win_diff  = {1'b0, off} - base;
   assign in_win    = ({1'b0, off} >= base) && ({1'b0, off} < base + BUF_LEN);
   assign clk_off   = is_new ? 8'h0C : 8'h18;
   assign user_off  = is_new ? 8'h10 : 8'h1C;
   assign misc_off  = is_new ? 8'h20 : (is_leg ? 8'h2C : 8'h34);
   assign slave_off = is_new ? 8'hE0 : (is_leg ? 8'h30 : 8'h38);
   assign slave_idx = is_new ? SP_E0 : (is_leg ? SP_30 : SP_38);
   assign done_idx  = is_new ? SP_3C : (is_leg ? SP_30 : SP_38);
   assign done_mask = is_new ? 32'h0000_1000 : 32'h0000_0010;
   assign cmd_mask  = is_new ? 32'h0100_0000 : 32'h0004_0000;
   assign user_v    = is_new ? sp_ff[SP_10] : sp_ff[SP_1C];
   assign misc_v    = is_new ? sp_ff[SP_20] : (is_leg ? sp_ff[SP_2C] : sp_ff[SP_34]);
   assign clk_v     = is_new ? sp_ff[SP_0C] : sp_ff[SP_18];

   // transaction length in bits, then bytes capped at the buffer size
   always_comb begin
      if (is_leg) begin
         bits_a = user_v[27] ? {16'd0, sp_ff[SP_20][25:17]} + 25'd1 : 25'd0;
         bits_b = user_v[28] ? {16'd0, sp_ff[SP_20][16:8]} + 25'd1 : 25'd0;
      end else begin
         bits_a = user_v[27] ? {1'b0, sp_ff[SP_28][23:0]} + 25'd1 : 25'd0;
         bits_b = user_v[28] ? {1'b0, sp_ff[SP_2C][23:0]} + 25'd1 : 25'd0;
      end
      if (is_new) begin
         bits = {7'd0, sp_ff[SP_1C][17:0]} + 25'd1;
      end else begin
         bits = (bits_b > bits_a) ? bits_b : bits_a;
      end
      bytes_rnd = bits + 25'd7;
      nbytes    = bytes_rnd[24:3];
      cnt       = (nbytes < 22'(BUFFER_BYTES)) ? nbytes[6:0] : BUF_MAX;
   end

   assign nidx = byte_idx_ff + 7'd1;

   always_comb begin
      sp_in       = sp_ff;
      active_in   = active_ff;
      byte_idx_in = byte_idx_ff;
      byte_cnt_in = byte_cnt_ff;
      div_in      = div_ff;
      pol_in      = pol_ff;
      pha_in      = pha_ff;
      ord_in      = ord_ff;
      role_in     = role_ff;
      select_in   = select_ff;
      send_in     = 1'b0;
      lane_in     = 2'd0;
      rsel_in     = RSEL_NONE;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      dctl        = '0;
      w0          = req_write_value;
      md          = decode_mode(user_v, misc_v, sp_ff[SP_08], is_new);
      if (acc) begin
         case (req_mode)
            MODE_WR: begin
               if (sps.hit) begin
                  sp_in[sps.idx] = req_write_value;
               end else begin
                  mem_we = 1'b1;
               end
               if (in_win) begin
                  dctl.we      = 1'b1;
                  dctl.wr_word = win_diff[BUF_WORD_W+1:2];
                  dctl.be      = 4'hF;
                  dctl.wdata   = req_write_value;
               end else if (off == clk_off) begin
                  div_in = decode_clock(req_write_value, is_new);
               end else if (off == misc_off || off == user_off) begin
                  md     = decode_mode((off == user_off) ? req_write_value : user_v,
                                       (off == misc_off) ? req_write_value : misc_v,
                                       sp_ff[SP_08], is_new);
                  pol_in = md.pol;
                  pha_in = md.pha;
                  ord_in = md.ord;
               end else if (off == slave_off) begin
                  role_in = (is_new ? req_write_value[26] : req_write_value[30]) ?
                            ROLE_SLAVE : ROLE_MASTER;
                  if (!is_new && req_write_value[4]) begin
                     sp_in[slave_idx] = req_write_value & ~32'h0000_0010;
                  end
               end else if (is_new && off == 8'h38 && req_write_value[12]) begin
                  sp_in[SP_3C] = sp_ff[SP_3C] & ~32'h0000_1000;
               end else if (off == 8'h00) begin
                  if (is_new && req_write_value[23]) begin
                     w0[23] = 1'b0;
                  end
                  sp_in[SP_00] = w0;
                  // start is ignored while a transaction runs
                  if ((|(req_write_value & cmd_mask)) && !active_ff) begin
                     role_in     = ROLE_MASTER;
                     byte_cnt_in = cnt;
                     if (cnt == 7'd0) begin
                        sp_in[SP_00] = w0 & ~cmd_mask;
                     end else begin
                        div_in          = decode_clock(clk_v, is_new);
                        pol_in          = md.pol;
                        pha_in          = md.pha;
                        ord_in          = md.ord;
                        byte_idx_in     = 7'd0;
                        active_in       = 1'b1;
                        sp_in[done_idx] = sp_ff[done_idx] & ~done_mask;
                        if (sel_used_ff) begin
                           select_in = 1'b1;
                        end
                        send_in        = 1'b1;
                        dctl.rd_b_en   = 1'b1;
                        dctl.rd_b_word = '0;
                     end
                  end
               end
            end
            MODE_RD: begin
               if (in_win) begin
                  rsel_in        = RSEL_BUF;
                  dctl.rd_a_en   = 1'b1;
                  dctl.rd_a_word = win_diff[BUF_WORD_W+1:2];
               end else if (sps.hit) begin
                  rsel_in = RSEL_SPEC;
               end else begin
                  rsel_in = RSEL_MEM;
                  mem_re  = 1'b1;
               end
            end
            MODE_XCH: begin
               if (active_ff) begin
                  dctl.we      = 1'b1;
                  dctl.wr_word = byte_idx_ff[BUF_WORD_W+1:2];
                  dctl.be      = 4'b0001 << byte_idx_ff[1:0];
                  dctl.wdata   = {4{req_received_byte}};
                  byte_idx_in  = nidx;
                  if (nidx < byte_cnt_ff) begin
                     send_in        = 1'b1;
                     lane_in        = nidx[1:0];
                     dctl.rd_b_en   = 1'b1;
                     dctl.rd_b_word = nidx[BUF_WORD_W+1:2];
                  end else begin
                     active_in       = 1'b0;
                     sp_in[SP_00]    = sp_ff[SP_00] & ~cmd_mask;
                     sp_in[done_idx] = sp_ff[done_idx] | done_mask;
                     if (sel_used_ff) begin
                        select_in = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SP_N; i++) begin
            sp_ff[i] <= '0;
         end
         active_ff   <= 1'b0;
         byte_idx_ff <= '0;
         byte_cnt_ff <= '0;
         div_ff      <= 20'd1;
         pol_ff      <= 1'b0;
         pha_ff      <= 1'b0;
         ord_ff      <= 1'b0;
         role_ff     <= '0;
         select_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         send_ff     <= 1'b0;
         rsel_ff     <= RSEL_NONE;
      end else begin
         sp_ff       <= sp_in;
         active_ff   <= active_in;
         byte_idx_ff <= byte_idx_in;
         byte_cnt_ff <= byte_cnt_in;
         div_ff      <= div_in;
         pol_ff      <= pol_in;
         pha_ff      <= pha_in;
         ord_ff      <= ord_in;
         role_ff     <= role_in;
         select_ff   <= select_in;
         rsp_vld_ff  <= acc;
         send_ff     <= send_in;
         rsel_ff     <= rsel_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff    <= lane_in;
      spec_rd_ff <= sp_ff[sps.idx];
   end

   // general register words: one write and one registered read per beat
   always_ff @(posedge clock) begin
      if (mem_we) begin
         reg_mem[widx] <= req_write_value;
      end
      if (mem_re) begin
         mem_rd_ff <= reg_vld_ff[widx] ? reg_mem[widx] : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
      end else if (mem_we) begin
         reg_vld_ff[widx] <= 1'b1;
      end
   end

   spimb_dbuf #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_dbuf (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .rd_a_data(buf_rd_a),
      .rd_b_data(buf_rd_b)
   );

   always_comb begin
      case (rsel_ff)
         RSEL_MEM:  rsp_read_value = mem_rd_ff;
         RSEL_SPEC: rsp_read_value = spec_rd_ff;
         RSEL_BUF:  rsp_read_value = buf_rd_a;
         default:   rsp_read_value = 32'd0;
      endcase
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_send_start      = send_ff;
   assign rsp_send_byte       = send_ff ? buf_rd_b[8*lane_ff +: 8] : 8'd0;
   assign rsp_select_low      = select_ff;
   assign rsp_busy_res        = active_ff;
   assign rsp_clock_divider   = div_ff;
   assign rsp_idle_high       = pol_ff;
   assign rsp_sample_trailing = pha_ff;
   assign rsp_lsb_first       = ord_ff;
   assign rsp_role            = role_ff;

   a_rsp_follows_beat: assert property (@(posedge clock) disable iff (reset)
      acc |=> rsp_valid)
      else $error("response missing after accepted beat");

   a_send_while_active: assert property (@(posedge clock) disable iff (reset)
      rsp_send_start |-> (rsp_valid && active_ff))
      else $error("byte send outside a transaction");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (byte_idx_ff < byte_cnt_ff && byte_cnt_ff <= BUF_MAX))
      else $error("byte index past transaction length");

   a_read_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsel_ff != RSEL_NONE) |-> (rsp_valid && !rsp_send_start))
      else $error("read data on a non-read beat");

endmodule

@@ verif/tb_spi_master_buffered_controller_top.sv @@
// Self-checking testbench for spi_master_buffered_controller_top.
// Builds its own model of the register store, data buffer and transfer control, then
// drives bus accesses, byte-done beats and layout changes. Needs spimb_pkg and the RTL.
`timescale 1ns / 100ps

module tb_spi_master_buffered_controller_top
   import spimb_pkg::*;
;

   localparam logic [1:0] MODE_NONE   = 2'd3;
   localparam logic [1:0] LAY_CLASSIC = 2'd1;
   localparam logic [1:0] LAY_ALIAS   = 2'd3;
   localparam int         LIMIT       = 1000000;
   localparam int         BUF_BYTES   = 64;

   typedef enum logic [1:0] {K_BEAT, K_CSR, K_DRAIN} job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   mode;
      logic [7:0]   off;
      logic [31:0]  val;
      logic [7:0]   rx;
   } job_type;

   typedef struct packed {
      logic [31:0] rd;
      logic        ss;
      logic [7:0]  sb;
      logic        sel;
      logic        act;
      logic [19:0] div;
      logic        pol;
      logic        pha;
      logic        ord;
      logic [1:0]  role;
   } spi_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_mode = MODE_RD;
   logic [7:0]  req_byte_offset = 8'd0;
   logic [31:0] req_write_value = 32'd0;
   logic [7:0]  req_received_byte = 8'd0;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_LAYOUT;
   logic [1:0]  csr_wdata = 2'd0;
   logic        busy, rsp_valid, rsp_send_start, rsp_select_low, rsp_busy_res;
   logic        rsp_idle_high, rsp_sample_trailing, rsp_lsb_first;
   logic [31:0] rsp_read_value;
   logic [7:0]  rsp_send_byte;
   logic [19:0] rsp_clock_divider;
   logic [1:0]  rsp_role;

   spi_master_buffered_controller_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_byte_offset(req_byte_offset),
      .req_write_value(req_write_value), .req_received_byte(req_received_byte),
      .rsp_valid(rsp_valid), .rsp_read_value(rsp_read_value),
      .rsp_send_start(rsp_send_start), .rsp_send_byte(rsp_send_byte),
      .rsp_select_low(rsp_select_low), .rsp_busy_res(rsp_busy_res),
      .rsp_clock_divider(rsp_clock_divider), .rsp_idle_high(rsp_idle_high),
      .rsp_sample_trailing(rsp_sample_trailing), .rsp_lsb_first(rsp_lsb_first),
      .rsp_role(rsp_role), .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block
   logic [31:0] m_regs [64];
   logic [31:0] m_buf [16];
   int unsigned m_idx, m_cnt;
   logic        m_act, m_pol, m_pha, m_ord, m_sel, m_sel_used;
   logic [19:0] m_div;
   logic [1:0]  m_role, m_layout;

   job_type          pending_jobs[$];
   spi_status_type   expected_status[$];
   int               fail_count = 0;
   int               cycle_count = 0;

   function automatic logic lay_new();
      return m_layout == LAY_NEW;
   endfunction

   function automatic logic lay_leg();
      return m_layout == LAY_LEG;
   endfunction

   function automatic logic [7:0] window_base();
      return lay_new() ? 8'h98 : (lay_leg() ? 8'h40 : 8'h80);
   endfunction

   function automatic logic [7:0] clock_off();
      return lay_new() ? 8'h0C : 8'h18;
   endfunction

   function automatic logic [7:0] user_off();
      return lay_new() ? 8'h10 : 8'h1C;
   endfunction

   function automatic logic [7:0] misc_off();
      return lay_new() ? 8'h20 : (lay_leg() ? 8'h2C : 8'h34);
   endfunction

   function automatic logic [7:0] slave_off();
      return lay_new() ? 8'hE0 : (lay_leg() ? 8'h30 : 8'h38);
   endfunction

   function automatic logic [7:0] done_off();
      return lay_new() ? 8'h3C : (lay_leg() ? 8'h30 : 8'h38);
   endfunction

   function automatic logic [31:0] done_mask();
      return lay_new() ? 32'h1000 : 32'h10;
   endfunction

   function automatic logic [31:0] cmd_mask();
      return lay_new() ? 32'h0100_0000 : 32'h0004_0000;
   endfunction

   function automatic logic in_window(logic [7:0] off);
      int unsigned b;
      b = window_base();
      return int'(off) >= b && int'(off) < b + BUF_BYTES;
   endfunction

   function automatic logic [7:0] buf_byte(int unsigned i);
      logic [31:0] w;
      w = m_buf[i[5:2]];
      return w[i[1:0]*8 +: 8];
   endfunction

   function automatic void load_divider(logic [31:0] v);
      int unsigned pre, n;
      pre = (v >> 18) & (lay_new() ? 32'hF : 32'h1FFF);
      n   = (v >> 12) & 32'h3F;
      m_div = v[31] ? 20'd1 : 20'(((pre + 1) * (n + 1)) & 32'hFFFFF);
   endfunction

   function automatic void load_shape();
      logic [31:0] usr, msc, ctl;
      logic        edge_out;
      usr = m_regs[user_off() >> 2];
      msc = m_regs[misc_off() >> 2];
      ctl = m_regs[2];
      edge_out = lay_new() ? usr[9] : usr[7];
      m_pol = msc[29];
      m_pha = edge_out != msc[29];
      m_ord = lay_new() ? |ctl[26:25] : ctl[26];
   endfunction

   function automatic void begin_transfer(ref spi_status_type s);
      int unsigned nbits, b, nb;
      logic [31:0] usr, u1;
      if (m_act) return;
      m_role = ROLE_MASTER;
      usr = m_regs[user_off() >> 2];
      nbits = 0;
      if (lay_new()) begin
         nbits = (m_regs[7] & 32'h3FFFF) + 1;
      end else if (lay_leg()) begin
         u1 = m_regs[8];
         if (usr[27]) nbits = ((u1 >> 17) & 32'h1FF) + 1;
         if (usr[28]) begin
            b = ((u1 >> 8) & 32'h1FF) + 1;
            if (b > nbits) nbits = b;
         end
      end else begin
         if (usr[27]) nbits = (m_regs[10] & 32'hFFFFFF) + 1;
         if (usr[28]) begin
            b = (m_regs[11] & 32'hFFFFFF) + 1;
            if (b > nbits) nbits = b;
         end
      end
      nb = (nbits + 7) / 8;
      m_cnt = nb < BUF_BYTES ? nb : BUF_BYTES;
      if (m_cnt == 0) begin
         m_regs[0] &= ~cmd_mask();
         return;
      end
      load_divider(m_regs[clock_off() >> 2]);
      load_shape();
      m_idx = 0;
      m_act = 1'b1;
      m_regs[done_off() >> 2] &= ~done_mask();
      if (m_sel_used) m_sel = 1'b1;
      s.ss = 1'b1;
      s.sb = buf_byte(0);
   endfunction

   function automatic spi_status_type predict_status(job_type j);
      spi_status_type s;
      logic [7:0]  off;
      logic [5:0]  wi;
      off = j.off & 8'hFC;
      wi  = off[7:2];
      s = '0;
      if (j.mode == MODE_WR) begin
         m_regs[wi] = j.val;
         if (in_window(off)) begin
            m_buf[4'((off - window_base()) >> 2)] = j.val;
         end else if (off == clock_off()) begin
            load_divider(j.val);
         end else if (off == misc_off() || off == user_off()) begin
            load_shape();
         end else if (off == slave_off()) begin
            m_role = j.val[lay_new() ? 26 : 30] ? ROLE_SLAVE : ROLE_MASTER;
            if (!lay_new() && j.val[4]) m_regs[wi][4] = 1'b0;
         end else if (lay_new() && off == 8'h38 && j.val[12]) begin
            m_regs[15][12] = 1'b0;
         end else if (off == 8'h00) begin
            if (lay_new() && j.val[23]) m_regs[0][23] = 1'b0;
            if (j.val & cmd_mask()) begin_transfer(s);
         end
      end else if (j.mode == MODE_RD) begin
         s.rd = in_window(off) ? m_buf[4'((off - window_base()) >> 2)] : m_regs[wi];
      end else if (j.mode == MODE_XCH && m_act) begin
         m_buf[m_idx[5:2]][m_idx[1:0]*8 +: 8] = j.rx;
         m_idx = (m_idx + 1) & 32'h7F;
         if (m_idx < m_cnt) begin
            s.ss = 1'b1;
            s.sb = buf_byte(m_idx);
         end else begin
            m_act = 1'b0;
            m_regs[0] &= ~cmd_mask();
            m_regs[done_off() >> 2] |= done_mask();
            if (m_sel_used) m_sel = 1'b0;
         end
      end
      s.sel  = m_sel;
      s.act  = m_act;
      s.div  = m_div;
      s.pol  = m_pol;
      s.pha  = m_pha;
      s.ord  = m_ord;
      s.role = m_role;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // sample outputs, predict accepted beats, apply csr writes
   logic took = 1'b0;
   always @(posedge clock) begin
      spi_status_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected response", rsp_read_value, 32'd0);
            end else begin
               e = expected_status.pop_front();
               if (rsp_read_value !== e.rd) report_mismatch("read_value", rsp_read_value, e.rd);
               if (rsp_send_start !== e.ss)
                  report_mismatch("send_start", 32'(rsp_send_start), 32'(e.ss));
               if (rsp_send_byte !== e.sb)
                  report_mismatch("send_byte", 32'(rsp_send_byte), 32'(e.sb));
               if (rsp_select_low !== e.sel)
                  report_mismatch("select_low", 32'(rsp_select_low), 32'(e.sel));
               if (rsp_busy_res !== e.act)
                  report_mismatch("busy_res", 32'(rsp_busy_res), 32'(e.act));
               if (rsp_clock_divider !== e.div)
                  report_mismatch("clock_divider", 32'(rsp_clock_divider), 32'(e.div));
               if (rsp_idle_high !== e.pol)
                  report_mismatch("idle_high", 32'(rsp_idle_high), 32'(e.pol));
               if (rsp_sample_trailing !== e.pha)
                  report_mismatch("sample_trailing", 32'(rsp_sample_trailing), 32'(e.pha));
               if (rsp_lsb_first !== e.ord)
                  report_mismatch("lsb_first", 32'(rsp_lsb_first), 32'(e.ord));
               if (rsp_role !== e.role) report_mismatch("role", 32'(rsp_role), 32'(e.role));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_LAYOUT) m_layout = csr_wdata;
            else m_sel_used = csr_wdata[0];
         end
         if (start && !busy) begin
            expected_status.push_back(predict_status({K_BEAT, req_mode, req_byte_offset,
                                                      req_write_value, req_received_byte}));
         end
      end
      took <= start && !busy;
   end

   // driver: one beat at a time, random gaps, csr writes only once drained
   int gap = 0;
   int no_gap_run = 0;
   int quiet = 0;
   always @(negedge clock) begin
      job_type j;
      logic n_start, n_we;
      if (!reset) begin
         n_start = start && !took;
         n_we = 1'b0;
         if (!n_start) begin
            if (expected_status.size() == 0 && !start) quiet++;
            else quiet = 0;
            if (gap > 0) begin
               gap--;
            end else if (pending_jobs.size() > 0) begin
               j = pending_jobs[0];
               if (j.kind == K_BEAT) begin
                  void'(pending_jobs.pop_front());
                  req_mode <= j.mode;
                  req_byte_offset <= j.off;
                  req_write_value <= j.val;
                  req_received_byte <= j.rx;
                  n_start = 1'b1;
                  if (no_gap_run > 0) begin
                     no_gap_run--;
                     gap = 0;
                  end else if ($urandom_range(0, 9) == 0) begin
                     no_gap_run = $urandom_range(5, 40);
                     gap = 0;
                  end else begin
                     gap = $urandom_range(0, 17);
                  end
               end else if (quiet >= 3) begin
                  void'(pending_jobs.pop_front());
                  if (j.kind == K_CSR) begin
                     n_we = 1'b1;
                     csr_index <= j.off[0];
                     csr_wdata <= j.val[1:0];
                  end
                  quiet = 0;
               end
            end
         end
         start <= n_start;
         csr_we <= n_we;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus helpers
   logic [1:0] gen_layout;

   task automatic add_beat(logic [1:0] mode, logic [7:0] off, logic [31:0] val, logic [7:0] rx);
      pending_jobs.push_back({K_BEAT, mode, off, val, rx});
   endtask

   task automatic add_csr(logic idx, logic [1:0] val);
      pending_jobs.push_back({K_CSR, MODE_RD, {7'd0, idx}, {30'd0, val}, 8'd0});
      if (idx == CSR_LAYOUT) gen_layout = val;
   endtask

   task automatic add_drain();
      pending_jobs.push_back({K_DRAIN, MODE_RD, 8'd0, 32'd0, 8'd0});
   endtask

   function automatic logic [7:0] pick_offset();
      logic [7:0] hot [16] = '{8'h00, 8'h08, 8'h0C, 8'h10, 8'h18, 8'h1C, 8'h20, 8'h28,
                               8'h2C, 8'h30, 8'h34, 8'h38, 8'h3C, 8'hE0, 8'h40, 8'h98};
      if ($urandom_range(0, 2) == 0) return 8'($urandom);
      return hot[$urandom_range(0, 15)] | 8'($urandom_range(0, 3));
   endfunction

   // one well-formed transfer with random content
   task automatic add_transfer(int unsigned nbytes);
      logic [7:0]  base;
      logic [31:0] usr, cmd;
      int unsigned nbits;
      logic        is_n, is_l;
      is_n = gen_layout == LAY_NEW;
      is_l = gen_layout == LAY_LEG;
      base = is_n ? 8'h98 : (is_l ? 8'h40 : 8'h80);
      for (int k = 0; k < (nbytes + 3) / 4; k++)
         if ($urandom_range(0, 3) != 0) add_beat(MODE_WR, base + 8'(4 * k), $urandom, 8'd0);
      if ($urandom_range(0, 1)) add_beat(MODE_WR, is_n ? 8'h0C : 8'h18, $urandom, 8'd0);
      if ($urandom_range(0, 2) == 0) add_beat(MODE_WR, 8'h08, $urandom, 8'd0);
      if ($urandom_range(0, 2) == 0)
         add_beat(MODE_WR, is_n ? 8'h20 : (is_l ? 8'h2C : 8'h34), $urandom, 8'd0);
      nbits = nbytes * 8 - $urandom_range(0, 7);
      if (nbytes == 0) nbits = 0;
      usr = $urandom;
      usr[28:27] = 2'b01;
      if (is_n) begin
         add_beat(MODE_WR, 8'h1C, (32'($urandom) & ~32'h3FFFF) | (nbits - 1), 8'd0);
         add_beat(MODE_WR, 8'h10, usr, 8'd0);
      end else begin
         if (nbytes == 0) usr[27] = 1'b0;
         if (is_l) add_beat(MODE_WR, 8'h20, {6'($urandom), 9'(nbits - 1), 17'($urandom)}, 8'd0);
         else add_beat(MODE_WR, 8'h28, {8'($urandom), 24'(nbits - 1)}, 8'd0);
         add_beat(MODE_WR, 8'h1C, usr, 8'd0);
      end
      cmd = $urandom;
      cmd[is_n ? 24 : 18] = 1'b1;
      add_beat(MODE_WR, 8'h00, cmd, 8'd0);
      for (int k = 0; k < nbytes; k++) begin
         if ($urandom_range(0, 5) == 0) add_beat(MODE_RD, pick_offset(), $urandom, $urandom);
         add_beat(MODE_XCH, pick_offset(), $urandom, $urandom);
      end
      if ($urandom_range(0, 1)) add_beat(MODE_RD, base + 8'(4 * $urandom_range(0, 15)), 0, 0);
      if ($urandom_range(0, 1)) add_beat(MODE_RD, 8'h00, 0, 0);
   endtask

   initial begin
      int unsigned nb;
      for (int i = 0; i < 64; i++) m_regs[i] = '0;
      for (int i = 0; i < 16; i++) m_buf[i] = '0;
      m_idx = 0; m_cnt = 0; m_act = 0; m_div = 20'd1;
      m_pol = 0; m_pha = 0; m_ord = 0; m_role = 2'd0; m_sel = 0;
      m_layout = LAY_CLASSIC; m_sel_used = 1'b1;
      gen_layout = LAY_CLASSIC;

      // directed: extremes of each field, every mode, special cases
      add_beat(MODE_RD, 8'h00, 32'd0, 8'd0);
      add_beat(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
      add_beat(MODE_XCH, 8'h00, 32'd0, 8'hA5);                 // exchange while idle
      add_beat(MODE_WR, 8'h18, 32'h7FFF_F000, 8'd0);           // largest divider
      add_beat(MODE_WR, 8'h1C, 32'h0800_0000, 8'd0);
      add_beat(MODE_WR, 8'h28, 32'd0, 8'd0);
      add_beat(MODE_WR, 8'h00, 32'h0004_0000, 8'd0);           // one byte transfer
      add_beat(MODE_WR, 8'h00, 32'hFFFF_FFFF, 8'd0);           // start while active
      add_beat(MODE_XCH, 8'hFF, 32'd0, 8'hFF);
      add_beat(MODE_RD, 8'h80, 32'd0, 8'd0);
      add_beat(MODE_WR, 8'h18, 32'h8000_0000, 8'd0);
      add_beat(MODE_WR, 8'h38, 32'hFFFF_FFFF, 8'd0);           // slave write, bit 4 set
      add_beat(MODE_RD, 8'h38, 32'd0, 8'd0);
      add_beat(MODE_WR, 8'h1C, 32'd0, 8'd0);
      add_beat(MODE_WR, 8'h00, 32'h0004_0000, 8'd0);           // zero length
      add_beat(MODE_RD, 8'hFC, 32'd0, 8'd0);
      add_beat(MODE_WR, 8'h2C, 32'hFFFF_FFFF, 8'd0);
      add_beat(MODE_WR, 8'h1C, 32'h1000_0000, 8'd0);
      add_beat(MODE_WR, 8'h00, 32'h0004_0000, 8'd0);           // capped at the buffer size
      add_drain();

      for (int ph = 0; ph < 10; ph++) begin
         add_drain();
         add_csr(CSR_LAYOUT, ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
         add_csr(CSR_SEL_USED, ph == 0 ? 2'd0 : 2'($urandom_range(0, 1)));
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 9) < 6) begin
               nb = $urandom_range(0, 19) == 0 ? 64 : $urandom_range(0, 9);
               add_transfer(nb);
            end else begin
               for (int r = 0; r < 6; r++)
                  add_beat(2'($urandom_range(0, 3)), pick_offset(), $urandom, $urandom);
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_jobs.size() == 0 && !start && expected_status.size() == 0);
      repeat (5) @(posedge clock);
      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
